>>> hdl/sbd_pkg.sv
package sbd_pkg;

    localparam int ITEMS  = 1024;
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;
    localparam int BKT_W  = 64;
    localparam int CMD_W  = 3;
    localparam int BYTE_W = 8;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PASS  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FLAG  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ENTRY = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

    localparam logic CFG_REVERSE = 1'b0;
    localparam logic CFG_COUNT   = 1'b1;

    typedef struct packed {
        logic ahead;
        logic equal;
    } cmp_res_t;

endpackage

>>> hdl/sbd_cmp.sv
module sbd_cmp (
    input  logic [sbd_pkg::BKT_W-1:0] a_key,
    input  logic [sbd_pkg::IDX_W-1:0] a_item,
    input  logic [sbd_pkg::BKT_W-1:0] b_key,
    input  logic [sbd_pkg::IDX_W-1:0] b_item,
    input  logic                      reverse,
    output sbd_pkg::cmp_res_t         res
);
    import sbd_pkg::*;

    // bucket first, item number breaks ties
    always_comb
    begin
        res.equal = (a_key == b_key);
        if (a_key != b_key)
            res.ahead = (a_key < b_key);
        else if (reverse)
            res.ahead = (a_item > b_item);
        else
            res.ahead = (a_item < b_item);
    end

endmodule

>>> hdl/sort_based_bucket_dedup.sv
// channel   direction  handshake              payload
// request   in         in_valid / in_ready    command item_number bucket_value entry_position
// result    out        out_valid / out_ready  flag_duplicate entry_valid entry_item entry_bucket
//                                             entries_written active_items detected_items
// config    in         cfg_we                 cfg_index cfg_data
//
// load, read and unknown requests pass through the request latch and two chained
// memory reads of the result path (entry list, then bucket store).
// a pass runs an insertion sort, a scan and a split walk over n items; the split walk
// visits every sorted item once per split byte.
// clear flags sweeps every flag, one flag per cycle; the same sweep runs after
// reset, and no request is taken until it ends (config writes are taken always).
// in_ready is high only in idle; a result waiting for out_ready holds the sequencer.
module sort_based_bucket_dedup (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sbd_pkg::CMD_W-1:0]     command,
    input  logic [sbd_pkg::IDX_W-1:0]     item_number,
    input  logic [sbd_pkg::BKT_W-1:0]     bucket_value,
    input  logic [sbd_pkg::IDX_W-1:0]     entry_position,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          flag_duplicate,
    output logic                          entry_valid,
    output logic [sbd_pkg::IDX_W-1:0]     entry_item,
    output logic [sbd_pkg::BKT_W-1:0]     entry_bucket,
    output logic [sbd_pkg::CNT_W-1:0]     entries_written,
    output logic [sbd_pkg::CNT_W-1:0]     active_items,
    output logic [sbd_pkg::CNT_W-1:0]     detected_items,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [sbd_pkg::CNT_W-1:0]     cfg_data
);
    import sbd_pkg::*;

    // sequencer states
    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_INS_TOP = 4'd2;
    localparam logic [3:0] S_INS_KEY = 4'd3;
    localparam logic [3:0] S_INS_CHK = 4'd4;
    localparam logic [3:0] S_INS_RO  = 4'd5;
    localparam logic [3:0] S_INS_RB  = 4'd6;
    localparam logic [3:0] S_SCN_TOP = 4'd7;
    localparam logic [3:0] S_SCN_RO  = 4'd8;
    localparam logic [3:0] S_SCN_CHK = 4'd9;
    localparam logic [3:0] S_SPL_RD  = 4'd10;
    localparam logic [3:0] S_SPL_CHK = 4'd11;
    localparam logic [3:0] S_RSP1    = 4'd12;
    localparam logic [3:0] S_RSP2    = 4'd13;
    localparam logic [3:0] S_RSP3    = 4'd14;

    localparam int SCN_W = 1 + BYTE_W + IDX_W;

    // configuration
    logic             reverse_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] n_items;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reverse_reg <= 1'b0;
            count_reg   <= CNT_W'(ITEMS);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_REVERSE: reverse_reg <= cfg_data[0];
                CFG_COUNT:   count_reg   <= cfg_data;
                default:     ;
            endcase
        end
    end

    // counts above the store depth saturate
    assign n_items = (count_reg > CNT_W'(ITEMS)) ? CNT_W'(ITEMS) : count_reg;

    // sequencer registers
    logic [3:0]       state_reg, state_next;
    logic             rsp_pend_reg, rsp_pend_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [BYTE_W-1:0] s_reg, s_next;
    logic [BKT_W-1:0] key_reg, key_next;
    logic [IDX_W-1:0] o_reg, o_next;
    logic [CNT_W-1:0] ent_cnt_reg, ent_cnt_next;
    logic [CNT_W-1:0] act_cnt_reg, act_cnt_next;
    logic [CNT_W-1:0] det_cnt_reg, det_cnt_next;
    logic [CNT_W-1:0] ent_tot_reg, ent_tot_next;
    logic [CNT_W-1:0] act_tot_reg, act_tot_next;
    logic [CNT_W-1:0] det_tot_reg, det_tot_next;

    // latched request
    logic [IDX_W-1:0] item_reg;
    logic [IDX_W-1:0] pos_reg;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic             flag_out_reg;
    logic             ev_out_reg;
    logic [IDX_W-1:0] ei_out_reg;
    logic [BKT_W-1:0] eb_out_reg;
    logic [CNT_W-1:0] ew_out_reg;
    logic [CNT_W-1:0] act_out_reg;
    logic [CNT_W-1:0] det_out_reg;
    logic             out_load;

    // memory ports
    logic             bkt_we;
    logic [IDX_W-1:0] bkt_wa, bkt_ra;
    logic [BKT_W-1:0] bkt_wd, bkt_rd;
    logic             flg_we;
    logic [IDX_W-1:0] flg_wa, flg_ra;
    logic             flg_wd, flg_rd;
    logic             ord_we;
    logic [IDX_W-1:0] ord_wa, ord_ra;
    logic [IDX_W-1:0] ord_wd, ord_rd;
    logic             scn_we;
    logic [IDX_W-1:0] scn_wa, scn_ra;
    logic [SCN_W-1:0] scn_wd, scn_rd;
    logic             ent_we;
    logic [IDX_W-1:0] ent_wa, ent_ra;
    logic [IDX_W-1:0] ent_wd, ent_rd;

    logic [BKT_W-1:0] bkt_mem [ITEMS];
    logic             flg_mem [ITEMS];
    logic [IDX_W-1:0] ord_mem [ITEMS];
    logic [SCN_W-1:0] scn_mem [ITEMS];
    logic [IDX_W-1:0] ent_mem [ITEMS];

    always_ff @(posedge clk)
    begin
        if (bkt_we)
            bkt_mem[bkt_wa] <= bkt_wd;
        bkt_rd <= bkt_mem[bkt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (flg_we)
            flg_mem[flg_wa] <= flg_wd;
        flg_rd <= flg_mem[flg_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
            ord_mem[ord_wa] <= ord_wd;
        ord_rd <= ord_mem[ord_ra];
    end

    always_ff @(posedge clk)
    begin
        if (scn_we)
            scn_mem[scn_wa] <= scn_wd;
        scn_rd <= scn_mem[scn_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_wa] <= ent_wd;
        ent_rd <= ent_mem[ent_ra];
    end

    // shared compare unit: sort order in the sort, bucket equality in the scan
    cmp_res_t cmp;

    sbd_cmp u_cmp (
        .a_key   (key_reg),
        .a_item  (i_reg[IDX_W-1:0]),
        .b_key   (bkt_rd),
        .b_item  (o_reg),
        .reverse (reverse_reg),
        .res     (cmp)
    );

    logic             accept;
    logic [CNT_W-1:0] j_dec;
    logic             dup;
    logic             head;
    logic             spl_hit;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign j_dec    = j_reg - CNT_W'(1);
    // a repeat of the previous sorted bucket is a duplicate
    assign dup      = (i_reg != '0) && cmp.equal;
    assign head     = !dup && !flg_rd;
    assign spl_hit  = scn_rd[SCN_W-1] && (scn_rd[IDX_W +: BYTE_W] == s_reg);

    always_comb
    begin
        state_next    = state_reg;
        rsp_pend_next = rsp_pend_reg;
        clr_next      = clr_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        s_next        = s_reg;
        key_next      = key_reg;
        o_next        = o_reg;
        ent_cnt_next  = ent_cnt_reg;
        act_cnt_next  = act_cnt_reg;
        det_cnt_next  = det_cnt_reg;
        ent_tot_next  = ent_tot_reg;
        act_tot_next  = act_tot_reg;
        det_tot_next  = det_tot_reg;
        out_load      = 1'b0;

        bkt_we = 1'b0;  bkt_wa = item_number;  bkt_wd = bucket_value;
        bkt_ra = i_reg[IDX_W-1:0];
        flg_we = 1'b0;  flg_wa = clr_reg;  flg_wd = 1'b0;
        flg_ra = item_reg;
        ord_we = 1'b0;  ord_wa = j_reg[IDX_W-1:0];  ord_wd = i_reg[IDX_W-1:0];
        ord_ra = i_reg[IDX_W-1:0];
        scn_we = 1'b0;  scn_wa = i_reg[IDX_W-1:0];
        scn_wd = {head, bkt_rd[BYTE_W-1:0], o_reg};
        scn_ra = i_reg[IDX_W-1:0];
        ent_we = 1'b0;  ent_wa = ent_cnt_reg[IDX_W-1:0];  ent_wd = scn_rd[IDX_W-1:0];
        ent_ra = pos_reg;

        unique case (state_reg)
            S_CLR:
            begin
                flg_we   = 1'b1;
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(ITEMS - 1))
                    state_next = rsp_pend_reg ? S_RSP1 : S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        CMD_LOAD:
                        begin
                            bkt_we     = 1'b1;
                            state_next = S_RSP1;
                        end
                        CMD_PASS:
                        begin
                            i_next       = '0;
                            ent_cnt_next = '0;
                            act_cnt_next = '0;
                            det_cnt_next = '0;
                            state_next   = S_INS_TOP;
                        end
                        CMD_CLEAR:
                        begin
                            clr_next      = '0;
                            rsp_pend_next = 1'b1;
                            state_next    = S_CLR;
                        end
                        default: state_next = S_RSP1;
                    endcase
                end
            end
            // insertion sort: it = i, key = bucket of i
            S_INS_TOP:
            begin
                if (i_reg == n_items)
                begin
                    i_next     = '0;
                    state_next = S_SCN_TOP;
                end
                else
                    state_next = S_INS_KEY;
            end
            S_INS_KEY:
            begin
                key_next   = bkt_rd;
                j_next     = i_reg;
                state_next = S_INS_CHK;
            end
            S_INS_CHK:
            begin
                ord_ra = j_dec[IDX_W-1:0];
                if (j_reg == '0)
                begin
                    ord_we     = 1'b1;
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_INS_TOP;
                end
                else
                    state_next = S_INS_RO;
            end
            S_INS_RO:
            begin
                o_next     = ord_rd;
                bkt_ra     = ord_rd;
                state_next = S_INS_RB;
            end
            S_INS_RB:
            begin
                ord_we = 1'b1;
                if (cmp.ahead)
                begin
                    // shift the larger entry up one slot
                    ord_wd     = o_reg;
                    j_next     = j_dec;
                    state_next = S_INS_CHK;
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_INS_TOP;
                end
            end
            // scan in sorted order: flag repeats, mark group heads
            S_SCN_TOP:
            begin
                if (i_reg == n_items)
                begin
                    i_next     = '0;
                    s_next     = '0;
                    state_next = S_SPL_RD;
                end
                else
                    state_next = S_SCN_RO;
            end
            S_SCN_RO:
            begin
                o_next     = ord_rd;
                bkt_ra     = ord_rd;
                flg_ra     = ord_rd;
                state_next = S_SCN_CHK;
            end
            S_SCN_CHK:
            begin
                flg_wa   = o_reg;
                flg_wd   = 1'b1;
                flg_we   = dup;
                scn_we   = 1'b1;
                key_next = bkt_rd;
                if (dup)
                    det_cnt_next = det_cnt_reg + CNT_W'(1);
                if (head)
                    act_cnt_next = act_cnt_reg + CNT_W'(1);
                i_next     = i_reg + CNT_W'(1);
                state_next = S_SCN_TOP;
            end
            // split walk: one sweep of the sorted heads per split byte
            S_SPL_RD:
            begin
                if (i_reg == n_items)
                begin
                    i_next = '0;
                    s_next = s_reg + BYTE_W'(1);
                    if (s_reg == {BYTE_W{1'b1}})
                    begin
                        ent_tot_next = ent_cnt_reg;
                        act_tot_next = act_cnt_reg;
                        det_tot_next = det_cnt_reg;
                        state_next   = S_RSP1;
                    end
                end
                else
                    state_next = S_SPL_CHK;
            end
            S_SPL_CHK:
            begin
                if (spl_hit)
                begin
                    ent_we       = 1'b1;
                    ent_cnt_next = ent_cnt_reg + CNT_W'(1);
                end
                i_next     = i_reg + CNT_W'(1);
                state_next = S_SPL_RD;
            end
            // result reads: flag and entry, then bucket of the entry
            S_RSP1:
            begin
                rsp_pend_next = 1'b0;
                state_next    = S_RSP2;
            end
            S_RSP2:
            begin
                bkt_ra     = ent_rd;
                state_next = S_RSP3;
            end
            S_RSP3:
            begin
                bkt_ra = ent_rd;
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            rsp_pend_reg <= 1'b0;
            clr_reg      <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            s_reg        <= '0;
            ent_cnt_reg  <= '0;
            act_cnt_reg  <= '0;
            det_cnt_reg  <= '0;
            ent_tot_reg  <= '0;
            act_tot_reg  <= '0;
            det_tot_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rsp_pend_reg <= rsp_pend_next;
            clr_reg      <= clr_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            s_reg        <= s_next;
            ent_cnt_reg  <= ent_cnt_next;
            act_cnt_reg  <= act_cnt_next;
            det_cnt_reg  <= det_cnt_next;
            ent_tot_reg  <= ent_tot_next;
            act_tot_reg  <= act_tot_next;
            det_tot_reg  <= det_tot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid_next = out_load ? 1'b1 : (out_valid_reg && !out_ready);

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        o_reg   <= o_next;
        if (accept)
        begin
            item_reg <= item_number;
            pos_reg  <= entry_position;
        end
        if (out_load)
        begin
            flag_out_reg <= flg_rd;
            ev_out_reg   <= ({1'b0, pos_reg} < ent_tot_reg);
            ei_out_reg   <= ({1'b0, pos_reg} < ent_tot_reg) ? ent_rd : '0;
            eb_out_reg   <= ({1'b0, pos_reg} < ent_tot_reg) ? bkt_rd : '0;
            // counts held with the result so a later pass cannot change a waiting one
            ew_out_reg   <= ent_tot_reg;
            act_out_reg  <= act_tot_reg;
            det_out_reg  <= det_tot_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign flag_duplicate  = flag_out_reg;
    assign entry_valid     = ev_out_reg;
    assign entry_item      = ei_out_reg;
    assign entry_bucket    = eb_out_reg;
    assign entries_written = ew_out_reg;
    assign active_items    = act_out_reg;
    assign detected_items  = det_out_reg;

endmodule
